// ----- design/face_similarity_transform_fit_unit_macros.svh -----
// Assertion macros shared by the face similarity fit RTL.
// Included by the modules that carry checks; needs no package.
`ifndef FACE_SIMILARITY_TRANSFORM_FIT_UNIT_MACROS_SVH
`define FACE_SIMILARITY_TRANSFORM_FIT_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// A property that must hold at every clock edge out of reset.
`define FSTF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("fstf assertion failed");
// A condition that must never be seen at a clock edge out of reset.
`define FSTF_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("fstf forbidden condition seen");
`else
`define FSTF_ASSERT(lbl, clk, rstn, prop)
`define FSTF_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ----- design/fstf_pkg.sv -----
// Package for the face similarity fit: reference landmarks, derived
// normal-equation constants and the types shared between modules. No dependencies.
`default_nettype none

package fstf_pkg;

  // Reference landmarks in Q.16 pixels.
  localparam longint REF_X0 = 64'sd1985387;
  localparam longint REF_X1 = 64'sd4294692;
  localparam longint REF_X2 = 64'sd3147379;
  localparam longint REF_X3 = 64'sd2198687;
  localparam longint REF_X4 = 64'sd4111067;
  localparam longint REF_Y0 = 64'sd3387969;
  localparam longint REF_Y1 = 64'sd3375196;
  localparam longint REF_Y2 = 64'sd4701330;
  localparam longint REF_Y3 = 64'sd6053265;
  localparam longint REF_Y4 = 64'sd6042688;

  // Reference sums and the normal-equation determinant (Q.16 and Q.32).
  localparam longint SX = REF_X0 + REF_X1 + REF_X2 + REF_X3 + REF_X4;
  localparam longint SY = REF_Y0 + REF_Y1 + REF_Y2 + REF_Y3 + REF_Y4;
  localparam longint SQ = REF_X0 * REF_X0 + REF_X1 * REF_X1 + REF_X2 * REF_X2
                        + REF_X3 * REF_X3 + REF_X4 * REF_X4
                        + REF_Y0 * REF_Y0 + REF_Y1 * REF_Y1 + REF_Y2 * REF_Y2
                        + REF_Y3 * REF_Y3 + REF_Y4 * REF_Y4;
  localparam longint DEN = 5 * SQ - SX * SX - SY * SY;

  // Fit is good when Nc^2 + Ns^2 reaches the ceiling of den^2 / (2^16 * 1e8).
  localparam logic [127:0] THRESH = 128'd6553600000000;
  localparam logic [127:0] DEN_SQ = 128'(DEN) * 128'(DEN);
  localparam logic [127:0] S_MIN  = (DEN_SQ + THRESH - 128'd1) / THRESH;

  // Target-side centroid terms in Q.24, with and without the square shift.
  localparam longint SHIFT5  = 64'sd2621440;
  localparam longint MX_SQ   = ((SX + SHIFT5) * 256 + 2) / 5;
  localparam longint MX_RECT = (SX * 256 + 2) / 5;
  localparam longint MY      = (SY * 256 + 2) / 5;

  // Shared multiply / divide unit operation.
  typedef enum logic [0:0] {
    MDU_MUL = 1'b0,
    MDU_DIV = 1'b1
  } mdu_op_t;

  typedef struct packed {
    logic    start;
    mdu_op_t op;
  } mdu_req_t;

  // Point accumulator control.
  typedef struct packed {
    logic start;
    logic clear;
  } mac_ctl_t;

  function automatic logic [23:0] ref_x(input logic [2:0] k);
    logic [23:0] r;
    case (k)
      3'd0:    r = 24'(REF_X0);
      3'd1:    r = 24'(REF_X1);
      3'd2:    r = 24'(REF_X2);
      3'd3:    r = 24'(REF_X3);
      3'd4:    r = 24'(REF_X4);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [23:0] ref_y(input logic [2:0] k);
    logic [23:0] r;
    case (k)
      3'd0:    r = 24'(REF_Y0);
      3'd1:    r = 24'(REF_Y1);
      3'd2:    r = 24'(REF_Y2);
      3'd3:    r = 24'(REF_Y3);
      3'd4:    r = 24'(REF_Y4);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/fstf_mac.sv -----
// Landmark moment accumulator: one 25x21 multiply-accumulate per cycle.
// Depends on fstf_pkg for the reference table and control struct.
`default_nettype none

module fstf_mac (
  input  logic                clk,
  input  logic                rst_n,
  input  fstf_pkg::mac_ctl_t  ctl,
  input  logic signed [20:0]  pt_u,
  input  logic signed [20:0]  pt_v,
  input  logic [2:0]          pt_idx,
  output logic                done,
  output logic signed [47:0]  m0,
  output logic signed [47:0]  m1,
  output logic signed [23:0]  m2,
  output logic signed [23:0]  m3
);

  logic               busy_r;
  logic               done_r;
  logic [1:0]         cnt_r;
  logic signed [20:0] u_r;
  logic signed [20:0] v_r;
  logic [2:0]         idx_r;
  logic signed [47:0] m0_r;
  logic signed [47:0] m1_r;
  logic signed [23:0] m2_r;
  logic signed [23:0] m3_r;

  logic signed [24:0] ref_s;
  logic signed [20:0] opnd;
  logic signed [45:0] prod;
  logic signed [47:0] prod_ext;

  // Pick reference coordinate and landmark coordinate for this cycle.
  always_comb begin
    if (cnt_r == 2'd0 || cnt_r == 2'd3) begin
      ref_s = $signed({1'b0, fstf_pkg::ref_x(idx_r)});
    end else begin
      ref_s = $signed({1'b0, fstf_pkg::ref_y(idx_r)});
    end
    if (cnt_r == 2'd0 || cnt_r == 2'd2) begin
      opnd = u_r;
    end else begin
      opnd = v_r;
    end
  end

  assign prod     = ref_s * opnd;
  assign prod_ext = {{2{prod[45]}}, prod};

  // Landmark capture and operand hold.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      u_r   <= pt_u;
      v_r   <= pt_v;
      idx_r <= pt_idx;
    end
  end

  // Sequencing and the four moment sums.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      m0_r   <= '0;
      m1_r   <= '0;
      m2_r   <= '0;
      m3_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.clear) begin
        m0_r <= '0;
        m1_r <= '0;
        m2_r <= '0;
        m3_r <= '0;
      end else if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        m2_r   <= m2_r + {{3{pt_u[20]}}, pt_u};
        m3_r   <= m3_r + {{3{pt_v[20]}}, pt_v};
      end else if (busy_r) begin
        case (cnt_r)
          2'd0:    m0_r <= m0_r + prod_ext;
          2'd1:    m0_r <= m0_r + prod_ext;
          2'd2:    m1_r <= m1_r + prod_ext;
          default: m1_r <= m1_r - prod_ext;
        endcase
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign m0   = m0_r;
  assign m1   = m1_r;
  assign m2   = m2_r;
  assign m3   = m3_r;

endmodule

`default_nettype wire

// ----- design/fstf_mdu.sv -----
// Shared bit-serial unit: 64x64 unsigned multiply and 128/128 restoring divide
// over one 129-bit adder. Depends on fstf_pkg and the assertion macro header.
`default_nettype none
`include "face_similarity_transform_fit_unit_macros.svh"

module fstf_mdu (
  input  logic               clk,
  input  logic               rst_n,
  input  fstf_pkg::mdu_req_t req,
  input  logic [127:0]       op_a,
  input  logic [127:0]       op_b,
  output logic               busy,
  output logic               done,
  output logic [127:0]       acc,
  output logic [127:0]       quo
);

  logic              busy_r;
  logic              done_r;
  fstf_pkg::mdu_op_t op_r;
  logic [6:0]        cnt_r;
  logic [127:0]      acc_r;
  logic [127:0]      sh_r;
  logic [127:0]      arg_r;

  logic              is_div;
  logic              last;
  logic [128:0]      rs;
  logic [128:0]      base;
  logic [128:0]      addend;
  logic [128:0]      sum;

  // One adder: accumulate for multiply, trial subtract for divide.
  assign is_div = (op_r == fstf_pkg::MDU_DIV);
  assign rs     = {acc_r, sh_r[127]};
  assign base   = is_div ? rs : {1'b0, acc_r};
  assign addend = is_div ? ~{1'b0, arg_r} : {1'b0, sh_r};
  assign sum    = base + addend + {128'd0, is_div};
  assign last   = is_div ? (cnt_r == 7'd127) : (cnt_r == 7'd63);

  // Iteration control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= fstf_pkg::MDU_MUL;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        op_r   <= req.op;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 7'd1;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: product or remainder in acc_r, multiplicand or numerator/quotient in sh_r.
  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r <= '0;
      sh_r  <= op_a;
      arg_r <= op_b;
    end else if (busy_r) begin
      if (is_div) begin
        if (!sum[128]) begin
          acc_r <= sum[127:0];
          sh_r  <= {sh_r[126:0], 1'b1};
        end else begin
          acc_r <= rs[127:0];
          sh_r  <= {sh_r[126:0], 1'b0};
        end
      end else begin
        if (arg_r[0]) begin
          acc_r <= sum[127:0];
        end
        sh_r  <= {sh_r[126:0], 1'b0};
        arg_r <= {1'b0, arg_r[127:1]};
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign acc  = acc_r;
  assign quo  = sh_r;

  `FSTF_ASSERT_NEVER(a_mdu_start_busy, clk, rst_n, req.start && busy_r)
  `FSTF_ASSERT(a_mdu_done_after_busy, clk, rst_n, done_r |-> $past(busy_r))
  `FSTF_ASSERT_NEVER(a_mdu_mul_count, clk, rst_n, busy_r && !is_div && (cnt_r > 7'd63))

endmodule

`default_nettype wire

// ----- design/face_similarity_transform_fit_unit.sv -----
// Five-point nonreflective similarity fit: top level with solve sequencer.
// Points one to four each pass through accept, a 4-step MAC and a return to idle.
// The fifth point gives a result beat after 14 multiplies and 2 divides on the one
// shared unit, each with an issue step and a done step.
// A degenerate face ends after the sum of squares; a waiting result stalls input.
// Reset (rst_n, synchronous, low) clears point count, sums, control and sets 112x112.
`default_nettype none
`include "face_similarity_transform_fit_unit_macros.svh"

module face_similarity_transform_fit_unit (
  input  logic         clk,
  input  logic         rst_n,
  // tdata: point_x [20:0], point_y [41:21], zero [47:42]
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,
  // tdata: coef_xx [40:0], coef_xy [81:41], offset_x [122:82],
  //        coef_yx [163:123], coef_yy [204:164], offset_y [245:205], zero [247:246]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [247:0] out_tdata,
  // tuser: fit_ok [0]
  output logic         out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [12:0]  cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ACC   = 4'b0010,
    ST_SOLVE = 4'b0100,
    ST_HOLD  = 4'b1000
  } state_t;

  typedef enum logic [3:0] {
    SS_NC_A  = 4'd0,
    SS_NC_B  = 4'd1,
    SS_NS_A  = 4'd2,
    SS_NS_B  = 4'd3,
    SS_SQ_C  = 4'd4,
    SS_SQ_S  = 4'd5,
    SS_NUM_C = 4'd6,
    SS_DIV_C = 4'd7,
    SS_NUM_S = 4'd8,
    SS_DIV_S = 4'd9,
    SS_OX_A  = 4'd10,
    SS_OX_B  = 4'd11,
    SS_OY_A  = 4'd12,
    SS_OY_B  = 4'd13,
    SS_OFF_X = 4'd14,
    SS_OFF_Y = 4'd15
  } solve_step_t;

  localparam logic             CFG_WIDTH  = 1'b0;
  localparam logic             CFG_HEIGHT = 1'b1;
  localparam logic signed [65:0] O_MAX = 66'sd1099511627775;
  localparam logic signed [65:0] O_MIN = -66'sd1099511627776;
  // Reciprocal of 5 scaled by 2^60, rounded up; exact floor for operands below 2^58.
  localparam logic [63:0]      RECIP5 = ((64'd1 << 60) + 64'd4) / 64'd5;

  state_t             state_r;
  solve_step_t        step_r;
  logic               issued_r;
  logic [2:0]         points_seen_r;
  logic [12:0]        width_r;
  logic [12:0]        height_r;
  logic signed [53:0] nc_r;
  logic signed [53:0] ns_r;
  logic [127:0]       s_r;
  logic [127:0]       num_r;
  logic signed [39:0] cxx_r;
  logic signed [39:0] cyx_r;
  logic signed [65:0] ox_r;
  logic signed [65:0] oy_r;
  logic signed [40:0] offx_r;
  logic signed [40:0] offy_r;
  logic               ok_r;

  logic               out_valid_r;
  logic signed [40:0] o_cxx_r;
  logic signed [40:0] o_cxy_r;
  logic signed [40:0] o_offx_r;
  logic signed [40:0] o_cyx_r;
  logic signed [40:0] o_cyy_r;
  logic signed [40:0] o_offy_r;
  logic               o_ok_r;

  fstf_pkg::mac_ctl_t mac_ctl;
  logic               mac_done;
  logic signed [47:0] m0;
  logic signed [47:0] m1;
  logic signed [23:0] m2;
  logic signed [23:0] m3;

  fstf_pkg::mdu_req_t mdu_req;
  fstf_pkg::mdu_op_t  op_kind;
  logic [127:0]       op_a;
  logic [127:0]       op_b;
  logic               neg;
  logic               mdu_busy;
  logic               mdu_done;
  logic [127:0]       mdu_acc;
  logic [127:0]       mdu_quo;

  logic [23:0]        am2;
  logic [23:0]        am3;
  logic [53:0]        anc;
  logic [53:0]        ans;
  logic [39:0]        acxx;
  logic [39:0]        acyx;
  logic [65:0]        aox;
  logic [65:0]        aoy;
  logic signed [65:0] term;
  logic [127:0]       s_nxt;
  logic               rnd_up;
  logic [127:0]       q_rnd;
  logic [38:0]        q_mag;
  logic               coef_neg;
  logic signed [39:0] coef_nxt;
  logic               off_neg;
  logic signed [65:0] off_q;
  logic signed [65:0] mx;
  logic signed [65:0] off_full;
  logic signed [40:0] off_nxt;
  logic               load_out;
  logic signed [53:0] m0x5;
  logic signed [53:0] m1x5;

  // Point accumulator and shared multiply / divide unit.
  fstf_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .pt_u   (in_tdata[20:0]),
    .pt_v   (in_tdata[41:21]),
    .pt_idx (points_seen_r),
    .done   (mac_done),
    .m0     (m0),
    .m1     (m1),
    .m2     (m2),
    .m3     (m3)
  );

  fstf_mdu u_mdu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mdu_req),
    .op_a  (op_a),
    .op_b  (op_b),
    .busy  (mdu_busy),
    .done  (mdu_done),
    .acc   (mdu_acc),
    .quo   (mdu_quo)
  );

  // Magnitudes of signed operands.
  assign am2  = m2[23] ? 24'(-m2) : 24'(m2);
  assign am3  = m3[23] ? 24'(-m3) : 24'(m3);
  assign anc  = nc_r[53] ? 54'(-nc_r) : 54'(nc_r);
  assign ans  = ns_r[53] ? 54'(-ns_r) : 54'(ns_r);
  assign acxx = cxx_r[39] ? 40'(-cxx_r) : 40'(cxx_r);
  assign acyx = cyx_r[39] ? 40'(-cyx_r) : 40'(cyx_r);
  assign aox  = ox_r[65] ? 66'(-ox_r) : 66'(ox_r);
  assign aoy  = oy_r[65] ? 66'(-oy_r) : 66'(oy_r);
  assign m0x5 = ({{6{m0[47]}}, m0} <<< 2) + {{6{m0[47]}}, m0};
  assign m1x5 = ({{6{m1[47]}}, m1} <<< 2) + {{6{m1[47]}}, m1};

  // Operand selection for the current solve step.
  always_comb begin
    op_kind = fstf_pkg::MDU_MUL;
    op_a    = '0;
    op_b    = '0;
    neg     = 1'b0;
    case (step_r)
      SS_NC_A: begin
        op_a = 128'(am2);
        op_b = 128'(fstf_pkg::SX);
        neg  = m2[23];
      end
      SS_NC_B: begin
        op_a = 128'(am3);
        op_b = 128'(fstf_pkg::SY);
        neg  = m3[23];
      end
      SS_NS_A: begin
        op_a = 128'(am2);
        op_b = 128'(fstf_pkg::SY);
        neg  = m2[23];
      end
      SS_NS_B: begin
        op_a = 128'(am3);
        op_b = 128'(fstf_pkg::SX);
        neg  = m3[23];
      end
      SS_SQ_C: begin
        op_a = 128'(anc);
        op_b = 128'(anc);
      end
      SS_SQ_S: begin
        op_a = 128'(ans);
        op_b = 128'(ans);
      end
      SS_NUM_C: begin
        op_a = 128'(anc);
        op_b = 128'(fstf_pkg::DEN);
      end
      SS_DIV_C: begin
        op_kind = fstf_pkg::MDU_DIV;
        op_a    = num_r << 16;
        op_b    = s_r;
      end
      SS_NUM_S: begin
        op_a = 128'(ans);
        op_b = 128'(fstf_pkg::DEN);
      end
      SS_DIV_S: begin
        op_kind = fstf_pkg::MDU_DIV;
        op_a    = num_r << 16;
        op_b    = s_r;
      end
      SS_OX_A: begin
        op_a = 128'(acxx);
        op_b = 128'(am2);
        neg  = cxx_r[39] ^ m2[23];
      end
      SS_OX_B: begin
        op_a = 128'(acyx);
        op_b = 128'(am3);
        neg  = cyx_r[39] ^ m3[23];
      end
      SS_OY_A: begin
        op_a = 128'(acyx);
        op_b = 128'(am2);
        neg  = cyx_r[39] ^ m2[23];
      end
      SS_OY_B: begin
        op_a = 128'(acxx);
        op_b = 128'(am3);
        neg  = cxx_r[39] ^ m3[23];
      end
      // Divide by 1280 as a drop of 8 bits and a multiply by the reciprocal of 5.
      SS_OFF_X: begin
        op_a = (128'(aox) + 128'd640) >> 8;
        op_b = 128'(RECIP5);
      end
      SS_OFF_Y: begin
        op_a = (128'(aoy) + 128'd640) >> 8;
        op_b = 128'(RECIP5);
      end
      default: begin
        op_kind = fstf_pkg::MDU_MUL;
      end
    endcase
  end

  // Signed product term and running sum of squares.
  assign term  = neg ? -$signed({1'b0, mdu_acc[64:0]}) : $signed({1'b0, mdu_acc[64:0]});
  assign s_nxt = s_r + mdu_acc;

  // Coefficient rounding (half up on the magnitude) and clamp at 2^38.
  assign rnd_up   = ({mdu_acc, 1'b0} >= {1'b0, s_r});
  assign q_rnd    = mdu_quo + {127'd0, rnd_up};
  assign q_mag    = ((|q_rnd[127:39]) || (q_rnd[38] && (|q_rnd[37:0])))
                    ? {1'b1, 38'd0} : q_rnd[38:0];
  assign coef_neg = (step_r == SS_DIV_C) ? nc_r[53] : ns_r[53];
  assign coef_nxt = coef_neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});

  // Offset: centroid term minus rounded slope correction, saturated to 41 bits.
  // The quotient is the product shifted down by 60.
  assign off_neg  = (step_r == SS_OFF_X) ? ox_r[65] : oy_r[65];
  assign off_q    = off_neg ? -$signed({1'b0, mdu_acc[124:60]})
                            : $signed({1'b0, mdu_acc[124:60]});
  assign mx       = (step_r == SS_OFF_X)
                    ? ((width_r == height_r) ? 66'(fstf_pkg::MX_SQ) : 66'(fstf_pkg::MX_RECT))
                    : 66'(fstf_pkg::MY);
  assign off_full = mx - off_q;
  assign off_nxt  = (off_full > O_MAX) ? 41'(O_MAX)
                  : ((off_full < O_MIN) ? 41'(O_MIN) : 41'(off_full));

  // Handshakes and unit requests.
  assign in_tready     = (state_r == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign load_out      = (state_r == ST_HOLD) && (!out_valid_r || out_tready);
  assign mac_ctl.start = in_tvalid && in_tready;
  assign mac_ctl.clear = load_out;
  assign mdu_req.start = (state_r == ST_SOLVE) && !issued_r;
  assign mdu_req.op    = op_kind;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 13'd112;
      height_r <= 13'd112;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_data;
        CFG_HEIGHT: height_r <= cfg_data;
        default:    width_r  <= width_r;
      endcase
    end
  end

  // Face sequencer: accumulate points, then run the solve micro-steps.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      step_r        <= SS_NC_A;
      issued_r      <= 1'b0;
      points_seen_r <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid && in_tready) begin
            state_r <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (mac_done) begin
            if (points_seen_r == 3'd4) begin
              state_r  <= ST_SOLVE;
              step_r   <= SS_NC_A;
              issued_r <= 1'b0;
            end else begin
              points_seen_r <= points_seen_r + 3'd1;
              state_r       <= ST_IDLE;
            end
          end
        end
        ST_SOLVE: begin
          if (!issued_r) begin
            issued_r <= 1'b1;
          end else if (mdu_done) begin
            issued_r <= 1'b0;
            if (step_r == SS_OFF_Y) begin
              state_r <= ST_HOLD;
            end else if (step_r == SS_SQ_S && (s_nxt < fstf_pkg::S_MIN)) begin
              state_r <= ST_HOLD;
            end else begin
              step_r <= solve_step_t'(4'(step_r + 4'd1));
            end
          end
        end
        ST_HOLD: begin
          if (load_out) begin
            points_seen_r <= '0;
            state_r       <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Solve datapath: results of each step land in their working registers.
  always_ff @(posedge clk) begin
    if (state_r == ST_ACC && mac_done) begin
      nc_r <= m0x5;
      ns_r <= m1x5;
    end else if (state_r == ST_SOLVE && issued_r && mdu_done) begin
      case (step_r)
        SS_NC_A:  nc_r <= nc_r - term[53:0];
        SS_NC_B:  nc_r <= nc_r - term[53:0];
        SS_NS_A:  ns_r <= ns_r - term[53:0];
        SS_NS_B:  ns_r <= ns_r + term[53:0];
        SS_SQ_C:  s_r  <= mdu_acc;
        SS_SQ_S: begin
          s_r <= s_nxt;
          if (s_nxt < fstf_pkg::S_MIN) begin
            ok_r   <= 1'b0;
            cxx_r  <= '0;
            cyx_r  <= '0;
            offx_r <= '0;
            offy_r <= '0;
          end else begin
            ok_r <= 1'b1;
          end
        end
        SS_NUM_C: num_r  <= mdu_acc;
        SS_DIV_C: cxx_r  <= coef_nxt;
        SS_NUM_S: num_r  <= mdu_acc;
        SS_DIV_S: cyx_r  <= coef_nxt;
        SS_OX_A:  ox_r   <= term;
        SS_OX_B:  ox_r   <= ox_r - term;
        SS_OY_A:  oy_r   <= term;
        SS_OY_B:  oy_r   <= oy_r + term;
        SS_OFF_X: offx_r <= off_nxt;
        SS_OFF_Y: offy_r <= off_nxt;
        default:  ok_r   <= ok_r;
      endcase
    end
  end

  // Output register: holds one result beat until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_cxx_r  <= {cxx_r[39], cxx_r};
      o_cxy_r  <= -$signed({cyx_r[39], cyx_r});
      o_offx_r <= offx_r;
      o_cyx_r  <= {cyx_r[39], cyx_r};
      o_cyy_r  <= {cxx_r[39], cxx_r};
      o_offy_r <= offy_r;
      o_ok_r   <= ok_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, o_offy_r, o_cyy_r, o_cyx_r, o_offx_r, o_cxy_r, o_cxx_r};
  assign out_tuser  = o_ok_r;

  `FSTF_ASSERT_NEVER(a_points_range, clk, rst_n, points_seen_r > 3'd4)
  `FSTF_ASSERT_NEVER(a_mdu_overlap, clk, rst_n, mdu_req.start && mdu_busy)
  `FSTF_ASSERT_NEVER(a_mdu_out_of_solve, clk, rst_n, mdu_req.start && (state_r != ST_SOLVE))
  `FSTF_ASSERT(a_diag_tie, clk, rst_n, out_valid_r |-> (o_cxx_r == o_cyy_r))
  `FSTF_ASSERT(a_bad_fit_zero, clk, rst_n, (out_valid_r && !o_ok_r) |-> (o_cxx_r == '0 && o_offx_r == '0))

endmodule

`default_nettype wire
